// File: hw/rtl/skt_pkg.sv
// Shared definitions for the sorted key table: default sizes, operation
// codes and result status codes. No dependencies.
`default_nettype none

package skt_pkg;

    localparam int DEFAULT_DEPTH     = 16;
    localparam int DEFAULT_KEY_WIDTH = 32;

    // Fixed field widths on the stream ports
    localparam int OP_W     = 2;
    localparam int KEY_IN_W = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

endpackage

`default_nettype wire

// File: hw/rtl/skt_mem.sv
// Key storage for the sorted key table: one write port, one read port with
// registered read data. Defaults come from skt_pkg.
`default_nettype none

module skt_mem #(
    parameter int DEPTH = skt_pkg::DEFAULT_DEPTH,
    parameter int KEY_W = skt_pkg::DEFAULT_KEY_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [KEY_W-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [KEY_W-1:0]         o_rd_data
);
    import skt_pkg::*;

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_key_table.sv
// Sorted key table top level: handshakes, sequencer and output register.
// Uses skt_pkg for codes and defaults and skt_mem for key storage.
//
// Usage: one operation per input transfer on the slave stream (search,
// insert or delete of a key), one result transfer per operation on the
// master stream (found flag, status, entry count after the operation).
// Keys are kept ascending in a memory with one write port and one read port;
// one comparator checks the key against one stored entry at a time.
// Each operation scans up from entry 0 to the first key not below its own
// or past the last key; an insert then shifts the entries above that point
// up, from the top down, and writes the key; a delete that removes a key
// shifts the entries above it down. Refused operations (full, empty,
// unused code) go straight to the result without a scan.
// Each scan or shift step is one memory read, then a compare or a write
// back.
// o_s_tready is high only while the sequencer is idle. A finished result
// waits in the output register; the next operation may be taken meanwhile,
// and its result holds in the sequencer until the master side takes the
// earlier one. Reset empties the table at once; no clearing pass is run.
`default_nettype none

module sorted_key_table #(
    parameter int DEPTH     = skt_pkg::DEFAULT_DEPTH,
    parameter int KEY_WIDTH = skt_pkg::DEFAULT_KEY_WIDTH
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    // slave stream, tdata: operation[1:0], key[33:2], zeros above
    input  wire logic                                          i_s_tvalid,
    output logic                                               o_s_tready,
    input  wire logic [((skt_pkg::OP_W+skt_pkg::KEY_IN_W+7)/8)*8-1:0] i_s_tdata,
    // master stream, tdata: found[0], status[2:1], entry_count above, zeros
    output logic                                               o_m_tvalid,
    input  wire logic                                          i_m_tready,
    output logic [((3+$clog2(DEPTH+1)+7)/8)*8-1:0]             o_m_tdata
);
    import skt_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH+1);
    localparam int KW    = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
    localparam int OW    = ((3 + CW + 7) / 8) * 8;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD     = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_INS_RD = 3'd3;
    localparam logic [2:0] S_INS_WR = 3'd4;
    localparam logic [2:0] S_DEL_RD = 3'd5;
    localparam logic [2:0] S_DEL_WR = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]          r_state,  n_state;
    logic [OP_W-1:0]     r_op,     n_op;
    logic [KW-1:0]       r_key,    n_key;
    logic [CW-1:0]       r_idx,    n_idx;
    logic [CW-1:0]       r_pos,    n_pos;
    logic [CW-1:0]       r_count,  n_count;
    logic                r_found,  n_found;
    logic [STATUS_W-1:0] r_status, n_status;

    logic                r_out_valid, n_out_valid;
    logic                r_out_found, n_out_found;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [CW-1:0]       r_out_count, n_out_count;

    logic          in_xfer;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_data;
    logic          rd_en;
    logic [CW-1:0] rd_idx;
    logic [KW-1:0] rd_data;
    logic          key_lt;
    logic          key_eq;

    skt_mem #(
        .DEPTH (DEPTH),
        .KEY_W (KW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;

    // Shared comparator: stored entry against the operation's key
    assign key_lt = (rd_data < r_key);
    assign key_eq = (rd_data == r_key);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_count      = r_count;
        n_found      = r_found;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        wr_en        = 1'b0;
        wr_addr      = r_idx[AW-1:0];
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_idx       = r_idx;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op     = i_s_tdata[OP_W-1:0];
                    n_key    = i_s_tdata[OP_W +: KW];
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    priority if (i_s_tdata[OP_W-1:0] == OP_INSERT) begin
                        if (r_count == FULL_COUNT) begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_RD;
                        end
                    end else if (i_s_tdata[OP_W-1:0] == OP_DELETE) begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_RD;
                        end
                    end else if (i_s_tdata[OP_W-1:0] == OP_SEARCH) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_RD: begin
                if (r_idx == r_count) begin
                    // ran past the last key: no entry is greater or equal
                    priority if (r_op == OP_INSERT) begin
                        n_pos   = r_idx;
                        n_idx   = r_count;
                        n_state = S_INS_RD;
                    end else if (r_op == OP_DELETE) begin
                        n_status = ST_MISSING;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (key_lt) begin
                    n_idx   = r_idx + ONE;
                    n_state = S_RD;
                end else begin
                    priority if (r_op == OP_INSERT) begin
                        n_pos   = r_idx;
                        n_idx   = r_count;
                        n_state = S_INS_RD;
                    end else if (r_op == OP_DELETE) begin
                        if (key_eq) begin
                            n_state = S_DEL_RD;
                        end else begin
                            n_status = ST_MISSING;
                            n_state  = S_OUT;
                        end
                    end else begin
                        n_found = key_eq;
                        n_state = S_OUT;
                    end
                end
            end
            S_INS_RD: begin
                if (r_idx == r_pos) begin
                    wr_en   = 1'b1;
                    wr_data = r_key;
                    n_count = r_count + ONE;
                    n_state = S_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_idx  = r_idx - ONE;
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                // move the entry below up by one
                wr_en   = 1'b1;
                n_idx   = r_idx - ONE;
                n_state = S_INS_RD;
            end
            S_DEL_RD: begin
                if (r_idx + ONE == r_count) begin
                    n_count = r_count - ONE;
                    n_found = 1'b1;
                    n_state = S_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_idx  = r_idx + ONE;
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                // move the entry above down by one
                wr_en   = 1'b1;
                n_idx   = r_idx + ONE;
                n_state = S_DEL_RD;
            end
            S_OUT: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_found;
                    n_out_status = r_status;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_found      <= n_found;
        r_status     <= n_status;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OW'({r_out_count, r_out_status, r_out_found});

endmodule

`default_nettype wire

// File: tb/skt_checker.sv
// Checker for the sorted key table: watches both stream channels, keeps its
// own ordered key list and compares each result transfer. Uses skt_pkg.
`timescale 1ns / 100ps

module skt_checker #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32,
    parameter int S_DATA_W  = 40,
    parameter int M_DATA_W  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    // operation[1:0], key[33:2], zeros above
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // found[0], status[2:1], entry_count above, zeros
    input  logic [M_DATA_W-1:0] i_m_tdata,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_hits,
    output int                  o_full_refusals
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // found lands in bit 0, as on the master tdata
    typedef struct packed {
        logic [CNT_W-1:0]    entry_count;
        logic [STATUS_W-1:0] status;
        logic                found;
    } t_key_reply;

    logic [KEY_WIDTH-1:0] table_keys [DEPTH];
    int                   table_count;
    t_key_reply           key_op_replies [$];
    int                   fail_total;
    int                   checked_total;
    int                   hit_total;
    int                   full_total;

    assign o_fail_count    = fail_total;
    assign o_checked       = checked_total;
    assign o_hits          = hit_total;
    assign o_full_refusals = full_total;

    task automatic apply_key_op(input logic [OP_W-1:0] op, input logic [KEY_WIDTH-1:0] key,
                                output t_key_reply reply);
        int pos;
        int i;
        reply = '0;
        pos = 0;
        // first held key that is not below the given one
        while (pos < table_count && table_keys[pos] < key)
            pos++;
        case (op)
            OP_SEARCH: begin
                reply.found = (pos < table_count) && (table_keys[pos] == key);
            end
            OP_INSERT: begin
                if (table_count >= DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    for (i = table_count; i > pos; i--)
                        table_keys[i] = table_keys[i-1];
                    table_keys[pos] = key;
                    table_count++;
                end
            end
            OP_DELETE: begin
                if (table_count == 0) begin
                    reply.status = ST_EMPTY;
                end else if (pos >= table_count || table_keys[pos] != key) begin
                    reply.status = ST_MISSING;
                end else begin
                    for (i = pos; i + 1 < table_count; i++)
                        table_keys[i] = table_keys[i+1];
                    table_count--;
                    reply.found = 1'b1;
                end
            end
            default: ;
        endcase
        reply.entry_count = CNT_W'(table_count);
    endtask

    always @(posedge i_clk) begin
        t_key_reply got;
        t_key_reply want;
        if (!i_rst_n) begin
            table_count = 0;
            key_op_replies.delete();
            fail_total    = 0;
            checked_total = 0;
            hit_total     = 0;
            full_total    = 0;
            o_pending    <= 0;
        end else begin
            // a result can never leave in the cycle its operation enters, so check first
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(t_key_reply)-1:0];
                checked_total++;
                if (key_op_replies.size() == 0) begin
                    $error("result transfer with no operation outstanding: tdata %h", i_m_tdata);
                    fail_total++;
                end else begin
                    want = key_op_replies.pop_front();
                    if (got.found !== want.found) begin
                        $error("found mismatch: expected %0d, got %0d", want.found, got.found);
                        fail_total++;
                    end
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                        fail_total++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        fail_total++;
                    end
                    if (want.found)
                        hit_total++;
                    if (want.status == ST_FULL)
                        full_total++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_key_op(i_s_tdata[OP_W-1:0], i_s_tdata[OP_W +: KEY_WIDTH], want);
                key_op_replies.push_back(want);
            end
            o_pending <= key_op_replies.size();
        end
    end

endmodule

// File: tb/sorted_key_table_test.sv
// Top of the sorted key table testbench: clock, reset, operation stimulus
// and result-side stalls. Needs skt_pkg, sorted_key_table and skt_checker.
`timescale 1ns / 100ps

module sorted_key_table_test;
    import skt_pkg::*;

    localparam int DEPTH      = DEFAULT_DEPTH;
    localparam int KEY_WIDTH  = DEFAULT_KEY_WIDTH;
    localparam int S_DATA_W   = ((OP_W + KEY_IN_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((3 + $clog2(DEPTH + 1) + 7) / 8) * 8;
    localparam int RANDOM_OPS = 1450;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 60;

    // code the block must answer with no change to the table
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum int { FILL_HEAVY, DRAIN_HEAVY, MIXED } t_op_mix;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;   // operation[1:0], key[33:2], zeros above
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;   // found[0], status[2:1], entry_count above

    int fail_count;
    int pending;
    int checked;
    int hits;
    int full_refusals;
    int idle_cycles;
    int op_tally [4];
    logic [KEY_WIDTH-1:0] recent_keys [$];
    logic                 steady_tx;

    sorted_key_table #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    skt_checker #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .S_DATA_W  (S_DATA_W),
        .M_DATA_W  (M_DATA_W)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_hits          (hits),
        .o_full_refusals (full_refusals)
    );

    always #1 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && recent_keys.size() != 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        if (r < 60)
            return KEY_WIDTH'($urandom_range(0, 7));
        if (r < 70) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return {1'b1, {(KEY_WIDTH-1){1'b0}}};
                default: return {1'b0, {(KEY_WIDTH-1){1'b1}}};
            endcase
        end
        return KEY_WIDTH'($urandom);
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input t_op_mix mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return OP_UNUSED;
        case (mix)
            FILL_HEAVY:  return (r < 65) ? OP_INSERT : (r < 82) ? OP_DELETE : OP_SEARCH;
            DRAIN_HEAVY: return (r < 22) ? OP_INSERT : (r < 75) ? OP_DELETE : OP_SEARCH;
            default:     return (r < 40) ? OP_INSERT : (r < 70) ? OP_DELETE : OP_SEARCH;
        endcase
    endfunction

    // hold the transfer until the block takes it, then maybe idle
    task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_WIDTH-1:0] key);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_DATA_W'({key, op});
        do @(posedge i_clk); while (!o_s_tready);
        op_tally[op]++;
        if (op == OP_INSERT) begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 24)
                void'(recent_keys.pop_front());
        end
        gap = steady_tx ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= S_DATA_W'({$urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // result side: ready bursts broken by stalls, some bursts long
    initial begin
        int run;
        int gap;
        i_m_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            i_m_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        t_op_mix mix;
        int      random_sent;
        int      block_len;
        int      i;
        logic [OP_W-1:0]      op;
        logic [KEY_WIDTH-1:0] key;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        steady_tx   = 1'b0;
        foreach (op_tally[j])
            op_tally[j] = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table corners, extremes, duplicates, then fill past full
        send_op(OP_SEARCH, '0);
        send_op(OP_DELETE, '0);
        send_op(OP_UNUSED, '1);
        send_op(OP_INSERT, '1);
        send_op(OP_INSERT, '0);
        send_op(OP_INSERT, '0);
        send_op(OP_SEARCH, '0);
        send_op(OP_SEARCH, '1);
        send_op(OP_SEARCH, KEY_WIDTH'(5));
        send_op(OP_DELETE, KEY_WIDTH'(5));
        send_op(OP_DELETE, '0);
        for (i = 1; i <= DEPTH - 2; i++)
            send_op(OP_INSERT, KEY_WIDTH'(i * 32'h1111_1111));
        send_op(OP_INSERT, KEY_WIDTH'(7));
        send_op(OP_UNUSED, '0);
        send_op(OP_DELETE, '1);
        wait_for_results();

        random_sent = 0;
        while (random_sent < RANDOM_OPS) begin
            mix       = t_op_mix'($urandom_range(0, 2));
            steady_tx = ($urandom_range(0, 3) == 0);
            block_len = $urandom_range(20, 80);
            if ($urandom_range(0, 4) == 0)
                wait_for_results();
            repeat (block_len) begin
                op  = pick_op(mix);
                key = pick_key();
                // flip one bit now and then so near misses show up among the hits
                if ($urandom_range(0, 9) == 0)
                    key ^= KEY_WIDTH'(1) << $urandom_range(0, KEY_WIDTH - 1);
                send_op(op, key);
                random_sent++;
            end
        end

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d searches, %0d inserts, %0d deletes, %0d unused codes",
                 op_tally[OP_SEARCH], op_tally[OP_INSERT], op_tally[OP_DELETE],
                 op_tally[OP_UNUSED]);
        $display("checked %0d results: %0d hits, %0d inserts refused on a full table",
                 checked, hits, full_refusals);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sorted_key_table.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_mem.sv
hw/rtl/sorted_key_table.sv
tb/skt_checker.sv
tb/sorted_key_table_test.sv
